### design/iibs_pkg.sv
// Shared types and constants for the integral image box-sum block.
// No dependencies; imported by integral_image_box_sum.
`default_nettype none

package iibs_pkg;

    localparam int CFG_W      = 9;   // widest configuration register
    localparam int CFG_IDX_W  = 1;
    localparam int PIX_W      = 8;
    localparam int COORD_W    = 8;
    localparam int SIZE_W     = 9;
    localparam int SUM_W      = 24;
    localparam int ROW_SUM_W  = 16;
    localparam int IN_DATA_W  = 48;  // 42 payload bits padded to bytes
    localparam int OUT_DATA_W = 24;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS = 1'd1;

    localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 9'd256;

    // beat kinds carried on tuser
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LD_WR,
        ST_QA,
        ST_QB,
        ST_QC,
        ST_QD,
        ST_QEND
    } t_state;

endpackage

`default_nettype wire

### design/integral_image_box_sum.sv
// Summed-area table builder with rectangle box-sum queries.
// Load: each pixel beat is accepted, then written to the table; no new beat is taken before the write.
// Query: 4 corner reads on the one read port, then the sum stage registers the result; the next
//   beat is taken once the sum stage is done, and the sum stage holds while a result waits.
// Reset (sync, active low): state, load position, row sum, sizes (256x256) and output valid cleared;
//   table memory is not cleared, entries are valid once written.
`default_nettype none

module integral_image_box_sum #(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 256
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // configuration write port
    input  wire                                 i_cfg_we,
    input  wire  [iibs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [iibs_pkg::CFG_W-1:0]          i_cfg_data,
    // input beats
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: pixel[7:0], left_x[15:8], top_y[23:16], box_width[32:24],
    //        box_height[41:33], zero[47:42]
    input  wire  [iibs_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // tuser: action[0]
    input  wire                                 s_axis_tuser,
    // result beats
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // tdata: box_sum[23:0]
    output logic [iibs_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    import iibs_pkg::*;

    localparam int XW    = $clog2(MAX_COLS);        // column index bits
    localparam int YW    = $clog2(MAX_ROWS);        // row index bits
    localparam int CVW   = $clog2(MAX_COLS + 1);    // column count bits
    localparam int RVW   = $clog2(MAX_ROWS + 1);    // row count bits
    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    // query coordinate math: corner plus size reaches 766
    localparam int QXW   = (CVW > 10) ? CVW : 10;
    localparam int QYW   = (RVW > 10) ? RVW : 10;

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    t_state               r_state, n_state;
    logic [CFG_W-1:0]     r_image_cols, r_image_rows;
    logic [XW-1:0]        r_col, n_col;
    logic [YW-1:0]        r_row, n_row;
    logic [ROW_SUM_W-1:0] r_rs, n_rs;

    // query corners, stored as coordinate minus one with a present flag
    logic [XW-1:0]        r_x0, r_x1, n_x0, n_x1;
    logic [YW-1:0]        r_y0, r_y1, n_y0, n_y1;
    logic                 r_hx0, r_hx1, r_hy0, r_hy1;
    logic                 n_hx0, n_hx1, n_hy0, n_hy1;
    logic [SUM_W-1:0]     r_acc, n_acc;

    logic                 r_out_valid, n_out_valid;
    logic [SUM_W-1:0]     r_out_sum, n_out_sum;

    // table memory, one read and one write port, registered read data
    logic [SUM_W-1:0]     r_table [DEPTH];
    logic [SUM_W-1:0]     r_rdata;

    logic                 mem_re, mem_we;
    logic [AW-1:0]        mem_raddr, mem_waddr;
    logic [SUM_W-1:0]     mem_wdata;

    // ---------------------------------------------------------------
    // Beat fields
    // ---------------------------------------------------------------
    logic [PIX_W-1:0]     in_pixel;
    logic [COORD_W-1:0]   in_left_x, in_top_y;
    logic [SIZE_W-1:0]    in_box_width, in_box_height;
    logic                 in_accept;
    logic                 out_free, out_load;

    assign in_pixel      = s_axis_tdata[7:0];
    assign in_left_x     = s_axis_tdata[15:8];
    assign in_top_y      = s_axis_tdata[23:16];
    assign in_box_width  = s_axis_tdata[32:24];
    assign in_box_height = s_axis_tdata[41:33];

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !r_out_valid || m_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_sum;

    function automatic logic [AW-1:0] tab_addr(input logic [XW-1:0] x,
                                                input logic [YW-1:0] y);
        tab_addr = AW'(y * MAX_COLS + x);
    endfunction

    // ---------------------------------------------------------------
    // Effective image size: 0 acts as 1, saturate at the table size
    // ---------------------------------------------------------------
    logic [CVW-1:0] cols_eff;
    logic [RVW-1:0] rows_eff;

    always_comb begin
        if (r_image_cols == '0) begin
            cols_eff = CVW'(1);
        end else if (r_image_cols > MAX_COLS) begin
            cols_eff = CVW'(MAX_COLS);
        end else begin
            cols_eff = CVW'(r_image_cols);
        end
        if (r_image_rows == '0) begin
            rows_eff = RVW'(1);
        end else if (r_image_rows > MAX_ROWS) begin
            rows_eff = RVW'(MAX_ROWS);
        end else begin
            rows_eff = RVW'(r_image_rows);
        end
    end

    // ---------------------------------------------------------------
    // Load position: fix up at accept in case the size shrank since
    // the last pixel, then advance after the write.
    // ---------------------------------------------------------------
    logic              pre_wrap;
    logic [YW:0]       pre_row_t;
    logic [YW-1:0]     pre_row;
    logic [XW-1:0]     pre_col;
    logic [ROW_SUM_W-1:0] pre_rs;

    logic [XW:0]       post_col_inc;
    logic              post_wrap;
    logic [YW:0]       post_row_t;
    logic [XW-1:0]     post_col;
    logic [YW-1:0]     post_row;

    always_comb begin
        pre_wrap  = {1'b0, r_col} >= cols_eff;
        pre_row_t = pre_wrap ? ({1'b0, r_row} + 1'b1) : {1'b0, r_row};
        pre_row   = (pre_row_t >= rows_eff) ? '0 : YW'(pre_row_t);
        pre_col   = pre_wrap ? '0 : r_col;
        pre_rs    = (pre_wrap ? '0 : r_rs) + ROW_SUM_W'(in_pixel);

        post_col_inc = {1'b0, r_col} + 1'b1;
        post_wrap    = post_col_inc >= cols_eff;
        post_row_t   = post_wrap ? ({1'b0, r_row} + 1'b1) : {1'b0, r_row};
        post_col     = post_wrap ? '0 : XW'(post_col_inc);
        post_row     = (post_row_t >= rows_eff) ? '0 : YW'(post_row_t);
    end

    // ---------------------------------------------------------------
    // Query corners: clamp both edges to the image, corner one before the rectangle
    // ---------------------------------------------------------------
    logic [QXW-1:0] q_sx, q_ex, q_ex_raw, q_cols;
    logic [QYW-1:0] q_sy, q_ey, q_ey_raw, q_rows;

    always_comb begin
        q_cols   = QXW'(cols_eff);
        q_rows   = QYW'(rows_eff);
        q_sx     = (QXW'(in_left_x) < q_cols) ? QXW'(in_left_x) : q_cols;
        q_sy     = (QYW'(in_top_y) < q_rows) ? QYW'(in_top_y) : q_rows;
        q_ex_raw = QXW'(in_left_x) + QXW'(in_box_width);
        q_ey_raw = QYW'(in_top_y) + QYW'(in_box_height);
        q_ex     = (q_ex_raw < q_cols) ? q_ex_raw : q_cols;
        q_ey     = (q_ey_raw < q_rows) ? q_ey_raw : q_rows;
    end

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = (s_axis_tuser == ACT_LOAD) ? ST_LD_WR : ST_QA;
                end
            end
            ST_LD_WR: n_state = ST_IDLE;
            ST_QA:    n_state = ST_QB;
            ST_QB:    n_state = ST_QC;
            ST_QC:    n_state = ST_QD;
            ST_QD:    n_state = ST_QEND;
            ST_QEND: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Outputs of the sequencer: memory ports, handshake, result load.
    // Corner data arrives in the cycle after its read; the sign of each
    // corner follows A - B - C + D.
    // ---------------------------------------------------------------
    logic [SUM_W-1:0] corner_a, corner_b, corner_c, corner_d;

    assign corner_a = (r_hx0 && r_hy0) ? r_rdata : '0;
    assign corner_b = (r_hx0 && r_hy1) ? r_rdata : '0;
    assign corner_c = (r_hx1 && r_hy0) ? r_rdata : '0;
    assign corner_d = (r_hx1 && r_hy1) ? r_rdata : '0;

    always_comb begin
        s_axis_tready = 1'b0;
        mem_re        = 1'b0;
        mem_raddr     = '0;
        mem_we        = 1'b0;
        mem_waddr     = tab_addr(r_col, r_row);
        mem_wdata     = SUM_W'(r_rs) + ((r_row != '0) ? r_rdata : '0);
        out_load      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                // entry above the pixel being loaded
                mem_re    = in_accept && (s_axis_tuser == ACT_LOAD);
                mem_raddr = tab_addr(pre_col, pre_row - 1'b1);
            end
            ST_LD_WR: mem_we = 1'b1;
            ST_QA: begin
                mem_re    = 1'b1;
                mem_raddr = tab_addr(r_x0, r_y0);
            end
            ST_QB: begin
                mem_re    = 1'b1;
                mem_raddr = tab_addr(r_x0, r_y1);
            end
            ST_QC: begin
                mem_re    = 1'b1;
                mem_raddr = tab_addr(r_x1, r_y0);
            end
            ST_QD: begin
                mem_re    = 1'b1;
                mem_raddr = tab_addr(r_x1, r_y1);
            end
            ST_QEND:  out_load = out_free;
            default:  out_load = 1'b0;
        endcase
    end

    // ---------------------------------------------------------------
    // Datapath next values
    // ---------------------------------------------------------------
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_rs  = r_rs;
        n_x0  = r_x0;
        n_x1  = r_x1;
        n_y0  = r_y0;
        n_y1  = r_y1;
        n_hx0 = r_hx0;
        n_hx1 = r_hx1;
        n_hy0 = r_hy0;
        n_hy1 = r_hy1;
        n_acc = r_acc;
        case (r_state)
            ST_IDLE: begin
                if (in_accept && (s_axis_tuser == ACT_LOAD)) begin
                    n_col = pre_col;
                    n_row = pre_row;
                    n_rs  = pre_rs;
                end
                if (in_accept && (s_axis_tuser == ACT_QUERY)) begin
                    n_hx0 = q_sx != '0;
                    n_hy0 = q_sy != '0;
                    n_hx1 = q_ex != '0;
                    n_hy1 = q_ey != '0;
                    n_x0  = (q_sx != '0) ? XW'(q_sx - 1'b1) : '0;
                    n_y0  = (q_sy != '0) ? YW'(q_sy - 1'b1) : '0;
                    n_x1  = (q_ex != '0) ? XW'(q_ex - 1'b1) : '0;
                    n_y1  = (q_ey != '0) ? YW'(q_ey - 1'b1) : '0;
                end
            end
            ST_LD_WR: begin
                n_col = post_col;
                n_row = post_row;
                if (post_wrap) begin
                    n_rs = '0;
                end
            end
            ST_QB:   n_acc = corner_a;
            ST_QC:   n_acc = r_acc - corner_b;
            ST_QD:   n_acc = r_acc - corner_c;
            default: n_acc = r_acc;
        endcase
    end

    always_comb begin
        n_out_sum   = r_out_sum;
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_sum   = r_acc + corner_d;
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_col        <= '0;
            r_row        <= '0;
            r_rs         <= '0;
            r_out_valid  <= 1'b0;
            r_image_cols <= CFG_SIZE_RESET;
            r_image_rows <= CFG_SIZE_RESET;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_row       <= n_row;
            r_rs        <= n_rs;
            r_out_valid <= n_out_valid;
            if (i_cfg_we && (i_cfg_index == CFG_IMAGE_COLS)) begin
                r_image_cols <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_index == CFG_IMAGE_ROWS)) begin
                r_image_rows <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_x0      <= n_x0;
        r_x1      <= n_x1;
        r_y0      <= n_y0;
        r_y1      <= n_y1;
        r_hx0     <= n_hx0;
        r_hx1     <= n_hx1;
        r_hy0     <= n_hy0;
        r_hy1     <= n_hy1;
        r_acc     <= n_acc;
        r_out_sum <= n_out_sum;
    end

    // table memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_table[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= r_table[mem_raddr];
        end
    end

`ifndef SYNTHESIS
    // a pixel beat is written to the table in the very next cycle
    a_load_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (s_axis_tuser == ACT_LOAD)) |=> mem_we)
        else $error("load beat not written to table");

    // four corner reads, then the sum stage
    a_query_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (s_axis_tuser == ACT_QUERY)) |=> ##4 (r_state == ST_QEND))
        else $error("query did not reach sum stage on time");

    // after a write the load position lies inside the image
    a_pos_in_image: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LD_WR) |=>
            (({1'b0, r_col} < $past(cols_eff)) && ({1'b0, r_row} < $past(rows_eff))))
        else $error("load position outside image");

    // a table write never coincides with a corner read
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (!mem_re && !s_axis_tready))
        else $error("table write overlaps a read or an accept");
`endif

endmodule

`default_nettype wire

### test/integral_image_box_sum_tb.sv
// Testbench for integral_image_box_sum: pixel loads and box queries on the stream ports.
// A local summed-area model predicts each box sum. Needs iibs_pkg and the block's RTL.
module integral_image_box_sum_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import iibs_pkg::*;

    localparam int MAX_COLS = 256;
    localparam int MAX_ROWS = 256;
    localparam int SAT_DEPTH = MAX_COLS * MAX_ROWS;
    // a load beat gives no result; let its table write land before a register write
    localparam int LOAD_SETTLE_CYCLES = 6;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_W-1:0]      i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // tdata: pixel, left_x, top_y, box_width, box_height, zero pad (lowest bit up)
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    // tuser: action
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // tdata: box_sum
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    integral_image_box_sum #(
        .MAX_COLS(MAX_COLS),
        .MAX_ROWS(MAX_ROWS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // ------------------------------------------------------------------
    // Summed-area table model. sat_known marks entries whose value is
    // defined in the block's memory; queries only touch known entries.
    // ------------------------------------------------------------------
    logic [SUM_W-1:0]     sat_mem   [0:SAT_DEPTH-1];
    bit                   sat_known [0:SAT_DEPTH-1];
    logic [ROW_SUM_W-1:0] sat_row_acc;
    logic [8:0]           sat_col;    // one spare bit for the step past the edge
    logic [8:0]           sat_row;
    logic [CFG_W-1:0]     size_cols_reg;
    logic [CFG_W-1:0]     size_rows_reg;

    logic [SUM_W-1:0]     pending_box_sums [$];
    int                   mismatch_count;
    bit                   idle_on;

    // size registers saturate to 1..max when used
    function automatic int unsigned eff_size(input logic [CFG_W-1:0] v, input int unsigned lim);
        if (v == '0) return 1;
        if (32'(v) > lim) return lim;
        return 32'(v);
    endfunction

    function automatic int unsigned cur_cols();
        return eff_size(size_cols_reg, MAX_COLS);
    endfunction

    function automatic int unsigned cur_rows();
        return eff_size(size_rows_reg, MAX_ROWS);
    endfunction

    // past the right edge: next row, fresh row sum; past the bottom: row 0
    function automatic void sat_wrap_position(input int unsigned cols, input int unsigned rows);
        if (32'(sat_col) >= cols) begin
            sat_col     = '0;
            sat_row     = sat_row + 1'b1;
            sat_row_acc = '0;
        end
        if (32'(sat_row) >= rows) sat_row = '0;
    endfunction

    function automatic void sat_load_pixel(input logic [PIX_W-1:0] pix);
        int unsigned      cols;
        int unsigned      rows;
        int unsigned      idx;
        logic [SUM_W-1:0] entry;
        cols = cur_cols();
        rows = cur_rows();
        sat_wrap_position(cols, rows);
        sat_row_acc = sat_row_acc + ROW_SUM_W'(pix);
        entry = {{(SUM_W-ROW_SUM_W){1'b0}}, sat_row_acc};
        idx = 32'(sat_row) * MAX_COLS + 32'(sat_col);
        sat_known[idx] = 1'b1;
        if (sat_row != '0) begin
            entry = entry + sat_mem[idx - MAX_COLS];
            sat_known[idx] = sat_known[idx - MAX_COLS];
        end
        sat_mem[idx] = entry;
        sat_col = sat_col + 1'b1;
        sat_wrap_position(cols, rows);
    endfunction

    // exclusive corners, stored plus one: 0 stands for coordinate -1
    function automatic void sat_clip(input logic [COORD_W-1:0] lx, input logic [COORD_W-1:0] ty,
                                     input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                                     output int unsigned sx, output int unsigned sy,
                                     output int unsigned ex, output int unsigned ey);
        int unsigned cols;
        int unsigned rows;
        cols = cur_cols();
        rows = cur_rows();
        sx = (32'(lx) < cols) ? 32'(lx) : cols;
        sy = (32'(ty) < rows) ? 32'(ty) : rows;
        ex = (32'(lx) + 32'(w) < cols) ? 32'(lx) + 32'(w) : cols;
        ey = (32'(ty) + 32'(h) < rows) ? 32'(ty) + 32'(h) : rows;
    endfunction

    function automatic logic [SUM_W-1:0] sat_corner(input int unsigned px, input int unsigned py);
        if (px == 0 || py == 0) return '0;
        return sat_mem[(py - 1) * MAX_COLS + (px - 1)];
    endfunction

    function automatic bit sat_corner_known(input int unsigned px, input int unsigned py);
        if (px == 0 || py == 0) return 1'b1;
        return sat_known[(py - 1) * MAX_COLS + (px - 1)];
    endfunction

    function automatic bit sat_box_readable(input logic [COORD_W-1:0] lx,
                                            input logic [COORD_W-1:0] ty,
                                            input logic [SIZE_W-1:0] w,
                                            input logic [SIZE_W-1:0] h);
        int unsigned sx, sy, ex, ey;
        sat_clip(lx, ty, w, h, sx, sy, ex, ey);
        return sat_corner_known(sx, sy) && sat_corner_known(sx, ey) &&
               sat_corner_known(ex, sy) && sat_corner_known(ex, ey);
    endfunction

    // A - B - C + D, wrapping at the sum width
    function automatic logic [SUM_W-1:0] sat_box_sum(input logic [COORD_W-1:0] lx,
                                                     input logic [COORD_W-1:0] ty,
                                                     input logic [SIZE_W-1:0] w,
                                                     input logic [SIZE_W-1:0] h);
        int unsigned sx, sy, ex, ey;
        sat_clip(lx, ty, w, h, sx, sy, ex, ey);
        return sat_corner(sx, sy) - sat_corner(sx, ey) - sat_corner(ex, sy) + sat_corner(ex, ey);
    endfunction

    // ------------------------------------------------------------------
    // Clock, result checking, receiver stalls
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : box_sum_check
        logic [SUM_W-1:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_box_sums.size() == 0) begin
                report_mismatch($sformatf("box_sum %06h with no query pending", m_axis_tdata));
            end else begin
                want = pending_box_sums.pop_front();
                if (m_axis_tdata !== want)
                    report_mismatch($sformatf("box_sum got %06h want %06h", m_axis_tdata, want));
            end
        end
    end

    // receiver back-pressure in random bursts while idle_on is set
    initial begin
        m_axis_tready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 9) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
        end
    end

    // generous cap on the whole run
    initial begin
        #8_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sender side. Every task enters and leaves on a falling edge.
    // ------------------------------------------------------------------
    task automatic send_beat(input logic act, input logic [PIX_W-1:0] pix,
                             input logic [COORD_W-1:0] lx, input logic [COORD_W-1:0] ty,
                             input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = act;
        s_axis_tdata  = {6'b0, h, w, ty, lx, pix};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        // beat taken at this edge: advance the model in acceptance order
        if (act == ACT_QUERY) pending_box_sums.push_back(sat_box_sum(lx, ty, w, h));
        else sat_load_pixel(pix);
        @(negedge i_clk);
    endtask

    task automatic load_pixel(input logic [PIX_W-1:0] pix);
        send_beat(ACT_LOAD, pix, COORD_W'($urandom), COORD_W'($urandom),
                  SIZE_W'($urandom), SIZE_W'($urandom));
    endtask

    task automatic query_box(input logic [COORD_W-1:0] lx, input logic [COORD_W-1:0] ty,
                             input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
        send_beat(ACT_QUERY, PIX_W'($urandom), lx, ty, w, h);
    endtask

    // mostly boxes inside the image; now and then any field value.
    // a box touching a never-written entry is redrawn, else falls back to empty at 0,0
    task automatic send_random_query();
        logic [COORD_W-1:0] lx, ty;
        logic [SIZE_W-1:0]  w, h;
        int                 tries;
        bit                 ok;
        ok = 1'b0;
        tries = 0;
        while (!ok && tries < 8) begin
            lx = COORD_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                      : $urandom_range(0, cur_cols() - 1));
            ty = COORD_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                      : $urandom_range(0, cur_rows() - 1));
            w  = SIZE_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 511)
                                                     : $urandom_range(0, cur_cols()));
            h  = SIZE_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 511)
                                                     : $urandom_range(0, cur_rows()));
            ok = sat_box_readable(lx, ty, w, h);
            tries++;
        end
        if (!ok) begin
            lx = '0;
            ty = '0;
            w  = '0;
            h  = '0;
        end
        query_box(lx, ty, w, h);
    endtask

    task automatic drain_results();
        s_axis_tvalid = 1'b0;
        while (pending_box_sums.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        if (idx == CFG_IMAGE_COLS) size_cols_reg = val;
        else size_rows_reg = val;
    endtask

    // registers change only with the block quiet
    task automatic write_size_regs(input logic [CFG_W-1:0] cols_val,
                                   input logic [CFG_W-1:0] rows_val);
        drain_results();
        repeat (LOAD_SETTLE_CYCLES) @(negedge i_clk);
        write_reg(CFG_IMAGE_COLS, cols_val);
        write_reg(CFG_IMAGE_ROWS, rows_val);
    endtask

    // finish the frame so a new size starts at row 0: every load then
    // adds an entry above that this frame already wrote
    task automatic complete_frame();
        while (sat_col != '0 || sat_row != '0) load_pixel(PIX_W'($urandom));
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] cols_val, input logic [CFG_W-1:0] rows_val,
                             input int n_beats, input int query_pct);
        complete_frame();
        write_size_regs(cols_val, rows_val);
        for (int i = 0; i < n_beats; i++) begin
            // now and then the sender holds off until the block has answered everything
            if ($urandom_range(0, 63) == 0) drain_results();
            if ($urandom_range(0, 99) < query_pct) send_random_query();
            else load_pixel(PIX_W'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // 4x3 image with extreme pixels, then every kind of box
    task automatic test_directed_small_image();
        logic [PIX_W-1:0] pix [0:11];
        pix = '{8'hff, 8'h00, 8'hff, 8'h00,
                8'h10, 8'h20, 8'h40, 8'h80,
                8'h01, 8'h02, 8'h04, 8'h08};
        write_size_regs(9'd4, 9'd3);
        foreach (pix[i]) load_pixel(pix[i]);
        query_box(8'd0,   8'd0,   9'd4,   9'd3);    // whole image
        query_box(8'd2,   8'd1,   9'd1,   9'd1);    // single pixel
        query_box(8'd1,   8'd1,   9'd2,   9'd2);    // interior
        query_box(8'd3,   8'd2,   9'd1,   9'd1);    // bottom-right pixel
        query_box(8'd255, 8'd0,   9'd5,   9'd3);    // left corner past the edge
        query_box(8'd0,   8'd255, 9'd4,   9'd3);    // top corner past the edge
        query_box(8'd1,   8'd1,   9'd0,   9'd2);    // zero width
        query_box(8'd1,   8'd1,   9'd2,   9'd0);    // zero height
        query_box(8'd1,   8'd1,   9'd256, 9'd256);  // far edges clamped
        query_box(8'd0,   8'd0,   9'd511, 9'd511);  // size fields all ones
        // frame complete: next pixel goes back to row 0, column 0
        load_pixel(8'h7f);
        query_box(8'd0,   8'd0,   9'd1,   9'd1);
        query_box(8'd0,   8'd0,   9'd4,   9'd3);
    endtask

    // shrink the image while part way through a frame
    task automatic test_resize_mid_frame();
        complete_frame();
        write_size_regs(9'd5, 9'd4);
        repeat (7) load_pixel(PIX_W'($urandom));   // now at row 1, column 2
        write_size_regs(9'd2, 9'd4);               // column 2 is past the edge
        repeat (3) load_pixel(PIX_W'($urandom));   // jumps to row 2
        query_box(8'd0, 8'd0, 9'd2, 9'd3);
        write_size_regs(9'd2, 9'd2);               // row 3 is past the bottom
        repeat (3) load_pixel(PIX_W'($urandom));
        query_box(8'd0, 8'd0, 9'd2, 9'd2);
        query_box(8'd1, 8'd0, 9'd1, 9'd2);
    endtask

    // widest, tallest and saturated register values
    task automatic test_size_extremes();
        run_phase(9'd256, 9'd2,   420, 25);
        run_phase(9'd0,   9'd511, 120, 30);        // 1 column by 256 rows
        run_phase(9'd511, 9'd0,   100, 30);        // 256 columns by 1 row
        run_phase(9'd0,   9'd0,   40,  40);        // single pixel image
    endtask

    task automatic test_random_sizes();
        run_phase(9'd8, 9'd6, 120, 30);
        repeat (3) run_phase(CFG_W'($urandom_range(1, 20)), CFG_W'($urandom_range(1, 16)),
                             50, 30);
    endtask

    // closing stretch with both sides always ready
    task automatic test_back_to_back();
        complete_frame();
        drain_results();
        idle_on = 1'b0;
        run_phase(9'd12, 9'd10, 150, 30);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = CFG_IMAGE_COLS;
        i_cfg_data     = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tuser   = ACT_LOAD;
        s_axis_tdata   = '0;
        idle_on        = 1'b1;
        mismatch_count = 0;
        sat_row_acc    = '0;
        sat_col        = '0;
        sat_row        = '0;
        size_cols_reg  = CFG_SIZE_RESET;
        size_rows_reg  = CFG_SIZE_RESET;
        foreach (sat_known[i]) sat_known[i] = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_small_image();
        test_resize_mid_frame();
        test_size_extremes();
        test_random_sizes();
        test_back_to_back();

        drain_results();
        repeat (20) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
